// ===== design/rgb_led_strip_range_driver_core_assert.svh =====
// ----------------------------------------------------------------------------
// RGB LED strip range driver - assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_STRIP_RANGE_DRIVER_CORE_ASSERT_SVH
`define RGB_LED_STRIP_RANGE_DRIVER_CORE_ASSERT_SVH

// same-cycle implication
`define RLSRD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLSRD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rlsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB LED strip range driver - package
// Shared widths, codes, beat types and register defaults.
// ----------------------------------------------------------------------------
package rlsrd_pkg;

	// strip size cap for led_count
	localparam int MAX_LEDS = 1024;

	localparam int LED_W        = 11;
	localparam int COLOR_W      = 8;
	localparam int PULSE_W      = 8;
	localparam int TICK_W       = 16;
	localparam int BIT_W        = 5;
	localparam int WORD_W       = 3 * COLOR_W;
	localparam int REG_IDX_W    = 8;
	localparam int REG_DATA_W   = 16;

	// register map
	typedef enum logic [REG_IDX_W-1:0] {
		REG_LED_COUNT   = 8'd0,
		REG_SHORT_TICKS = 8'd1,
		REG_LONG_TICKS  = 8'd2,
		REG_RESET_TICKS = 8'd3
	} reg_idx_t;

	// register reset values
	localparam logic [LED_W-1:0]   LED_COUNT_RST   = 11'd0;
	localparam logic [PULSE_W-1:0] SHORT_TICKS_RST = 8'd6;
	localparam logic [PULSE_W-1:0] LONG_TICKS_RST  = 8'd25;
	localparam logic [TICK_W-1:0]  RESET_TICKS_RST = 16'd2400;

	// last bit of an LED word
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WORD_W - 1);

	// line sequencer phase
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_SEND = 3'b010,
		PH_GAP  = 3'b100
	} phase_t;

	typedef struct packed {
		logic               action;
		logic [LED_W-1:0]   first_led;
		logic [LED_W-1:0]   end_led;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic command_rejected;
		logic frame_done;
	} result_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0]  reg_index;
		logic [REG_DATA_W-1:0] wdata;
	} cfg_beat_t;

	// register file contents handed to the sequencer
	typedef struct packed {
		logic [LED_W-1:0]   led_count;
		logic [PULSE_W-1:0] short_ticks;
		logic [PULSE_W-1:0] long_ticks;
		logic [TICK_W-1:0]  reset_ticks;
	} cfg_regs_t;

endpackage

// ===== design/rlsrd_chan_if.sv =====
// ----------------------------------------------------------------------------
// RGB LED strip range driver - channel interface
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface rlsrd_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rgb_led_strip_range_driver_core.sv =====
// ----------------------------------------------------------------------------
// RGB LED strip range driver - top level
// Input register, line sequencer step and result register for one-wire strips.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the result side is ready and
// returns one result for each: the beat is captured in an input register,
// the sequencer steps its frame state once from that register, and the
// result lands in an output register. The single sequencer step per cycle
// sets the throughput of one item per cycle; a stall on the result side
// holds both registers and deasserts items.ready, so no item is dropped.
// The configuration port is always ready and its writes act on the next
// step.
`include "rgb_led_strip_range_driver_core_assert.svh"

module rgb_led_strip_range_driver_core
	import rlsrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rlsrd_chan_if.sink   cfg,
	rlsrd_chan_if.sink   items,
	rlsrd_chan_if.source results
);

	cfg_regs_t regs;
	item_t     item_s1;
	logic      valid_s1;
	result_t   step_res;
	result_t   res_q;
	logic      res_valid_q;
	logic      adv;

	// configuration registers
	rlsrd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_beat  (cfg.data),
		.regs     (regs)
	);

	// the stage-1 beat moves on when the result register frees up
	assign adv         = valid_s1 && (!res_valid_q || results.ready);
	assign items.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.data;
		end
	end

	// sequencer
	rlsrd_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.item    (item_s1),
		.regs    (regs),
		.result  (step_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= step_res;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	// checks
	`RLSRD_ASSERT_NXT(a_step_lands, adv, res_valid_q, "stepped beat did not reach result register")
	`RLSRD_ASSERT_IMP(a_done_idle, res_valid_q && res_q.frame_done, !res_q.busy_res, "frame_done while still busy")
	`RLSRD_ASSERT_IMP(a_reject_busy, res_valid_q && res_q.command_rejected, res_q.busy_res, "rejected command while idle")

endmodule

// ===== design/rlsrd_cfg.sv =====
// ----------------------------------------------------------------------------
// RGB LED strip range driver - configuration registers
// Holds led_count and the pulse and gap durations; always ready.
// ----------------------------------------------------------------------------
module rlsrd_cfg
	import rlsrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  cfg_beat_t             wr_beat,
	output cfg_regs_t             regs
);

	cfg_regs_t regs_q;

	assign wr_ready = 1'b1;
	assign regs     = regs_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.led_count   <= LED_COUNT_RST;
			regs_q.short_ticks <= SHORT_TICKS_RST;
			regs_q.long_ticks  <= LONG_TICKS_RST;
			regs_q.reset_ticks <= RESET_TICKS_RST;
		end else if (wr_valid) begin
			unique case (wr_beat.reg_index)
				REG_LED_COUNT:   regs_q.led_count   <= wr_beat.wdata[LED_W-1:0];
				REG_SHORT_TICKS: regs_q.short_ticks <= wr_beat.wdata[PULSE_W-1:0];
				REG_LONG_TICKS:  regs_q.long_ticks  <= wr_beat.wdata[PULSE_W-1:0];
				REG_RESET_TICKS: regs_q.reset_ticks <= wr_beat.wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/rlsrd_engine.sv =====
// ----------------------------------------------------------------------------
// RGB LED strip range driver - line sequencer
// Frame state and the one-beat step: start, bit timing, LED advance, gap.
// ----------------------------------------------------------------------------
module rlsrd_engine
	import rlsrd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  item_t     item,
	input  cfg_regs_t regs,
	output result_t   result
);

	phase_t              phase_q, phase_n;
	logic [LED_W-1:0]    led_index_q, led_index_n;
	logic [BIT_W-1:0]    bit_index_q, bit_index_n;
	logic                second_half_q, second_half_n;
	logic [TICK_W-1:0]   tick_q, tick_n;
	logic [WORD_W-1:0]   shift_q, shift_n;
	logic [WORD_W-1:0]   colour_q, colour_n;
	logic [LED_W-1:0]    first_q, first_n;
	logic [LED_W-1:0]    end_q, end_n;

	logic [LED_W-1:0]    frame_len;
	logic [TICK_W-1:0]   tick_inc;
	logic [PULSE_W-1:0]  dur;
	logic [LED_W-1:0]    led_next;
	logic [WORD_W-1:0]   next_word;
	logic                rejected;
	logic                done;

	// led_count saturated to the strip cap
	assign frame_len = (int'(regs.led_count) > MAX_LEDS) ? LED_W'(MAX_LEDS) : regs.led_count;

	assign tick_inc  = tick_q + 1'b1;
	assign dur       = (shift_q[WORD_W-1] ^ second_half_q) ? regs.long_ticks : regs.short_ticks;
	assign led_next  = led_index_q + 1'b1;
	assign next_word = (led_next >= first_q && led_next < end_q) ? colour_q : '0;

	// one step of the line waveform
	always_comb begin
		phase_n       = phase_q;
		led_index_n   = led_index_q;
		bit_index_n   = bit_index_q;
		second_half_n = second_half_q;
		tick_n        = tick_q;
		shift_n       = shift_q;
		colour_n      = colour_q;
		first_n       = first_q;
		end_n         = end_q;
		rejected      = 1'b0;
		done          = 1'b0;

		if (item.action) begin
			if (phase_q != PH_IDLE) begin
				rejected = 1'b1;
			end else begin
				first_n       = item.first_led;
				end_n         = item.end_led;
				colour_n      = {item.green, item.red, item.blue};
				led_index_n   = '0;
				bit_index_n   = '0;
				second_half_n = 1'b0;
				tick_n        = '0;
				if (frame_len == '0) begin
					phase_n = PH_GAP;
					shift_n = '0;
				end else begin
					phase_n = PH_SEND;
					shift_n = (item.first_led == '0 && item.end_led != '0) ?
						{item.green, item.red, item.blue} : '0;
				end
			end
		end else begin
			unique case (phase_q)
				PH_SEND: begin
					tick_n = tick_inc;
					if (tick_inc >= {{(TICK_W-PULSE_W){1'b0}}, dur}) begin
						tick_n = '0;
						if (!second_half_q) begin
							second_half_n = 1'b1;
						end else begin
							second_half_n = 1'b0;
							shift_n       = {shift_q[WORD_W-2:0], 1'b0};
							bit_index_n   = bit_index_q + 1'b1;
							if (bit_index_q == LAST_BIT) begin
								bit_index_n = '0;
								led_index_n = led_next;
								if (led_next >= frame_len) begin
									phase_n = PH_GAP;
									shift_n = '0;
								end else begin
									shift_n = next_word;
								end
							end
						end
					end
				end
				PH_GAP: begin
					tick_n = tick_inc;
					if (tick_inc >= regs.reset_ticks) begin
						tick_n      = '0;
						phase_n     = PH_IDLE;
						led_index_n = '0;
						done        = 1'b1;
					end
				end
				default: ;
			endcase
		end

		result.line_level       = (phase_q == PH_SEND) && !second_half_q;
		result.busy_res         = (phase_n != PH_IDLE);
		result.command_rejected = rejected;
		result.frame_done       = done;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			led_index_q   <= '0;
			bit_index_q   <= '0;
			second_half_q <= 1'b0;
			tick_q        <= '0;
			shift_q       <= '0;
			colour_q      <= '0;
			first_q       <= '0;
			end_q         <= '0;
		end else if (step_en) begin
			phase_q       <= phase_n;
			led_index_q   <= led_index_n;
			bit_index_q   <= bit_index_n;
			second_half_q <= second_half_n;
			tick_q        <= tick_n;
			shift_q       <= shift_n;
			colour_q      <= colour_n;
			first_q       <= first_n;
			end_q         <= end_n;
		end
	end

endmodule
